// ===== src/ffmst_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants for the first-fit max segment tree allocator.
// Used by the top level and its checker; has no dependencies.
package ffmst_pkg;

  localparam int SLOTS_DEFAULT      = 1024;
  localparam int VALUE_BITS_DEFAULT = 30;

  localparam int SLOT_W   = 10;
  localparam int AMOUNT_W = 30;
  localparam int GRANT_W  = 11;

  // slot in the low bits, amount above it, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

endpackage

// ===== src/ffmst_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffmst_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/first_fit_max_segment_tree.sv =====
`timescale 1ns / 1ps
// First-fit capacity allocator over a max segment tree held in one RAM.
// Depends on ffmst_pkg and ffmst_ram.
//
// Usage:
//   Input stream (s_axis_*): tuser selects the request kind, 0 loads a slot's
//   capacity, 1 asks for an allocation. tdata carries slot and amount.
//   Output stream (m_axis_*): one result per allocation request, the 1-based
//   granted slot or 0 when nothing fits. Loads produce no result.
// Sequencing (L = clog2(SLOTS), 10 at the default size):
//   A load walks from its leaf up to the root before the next request can be
//   taken; a load to a slot outside the table is dropped and the block stays ready.
//   A fitting request reads the root, walks down to a leaf and back up; a
//   request that does not fit stops after the root read. Each tree level
//   costs one RAM read on the way down and one read-modify-write on the way up.
// Reset: rst starts a clearing pass that writes zero to all 2*2^L tree
//   entries; no request is taken until it ends.
// Stall: the result sits in an output register, so the block keeps taking
//   loads and requests while it waits; a second request finishing while the
//   previous result is still untaken waits until the receiver drains it.
module first_fit_max_segment_tree #(
  parameter int SLOTS      = ffmst_pkg::SLOTS_DEFAULT,
  parameter int VALUE_BITS = ffmst_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [9:0] slot, [39:10] amount
  input  logic [ffmst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [0] func
  input  logic                               s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [10:0] granted_slot, [15:11] zero
  output logic [ffmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  localparam int LEVELS    = $clog2(SLOTS);
  localparam int LEAF_BASE = 1 << LEVELS;
  localparam int DEPTH     = 2 * LEAF_BASE;
  localparam int AW        = LEVELS + 1;
  localparam int VW        = VALUE_BITS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_DESC  = 3'd3;
  localparam logic [2:0] ST_LEAF  = 3'd4;
  localparam logic [2:0] ST_UP    = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]                      state, state_next;
  logic [AW-1:0]                   clr_addr, clr_addr_next;
  logic [AW-1:0]                   node, node_next;
  logic [VW-1:0]                   cur, cur_next;
  logic [VW-1:0]                   amt, amt_next;
  logic                            is_req, is_req_next;
  logic [ffmst_pkg::GRANT_W-1:0]   grant, grant_next;
  logic                            m_valid_next;
  logic [ffmst_pkg::OUT_TDATA_W-1:0] m_data_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [VW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [VW-1:0] rd_data;

  logic [ffmst_pkg::SLOT_W-1:0]   in_slot;
  logic [ffmst_pkg::AMOUNT_W-1:0] in_amount;
  logic [VW-1:0]                  in_amt;
  logic                           slot_ok;
  logic [AW-1:0]                  leaf_addr;
  logic [AW-1:0]                  parent;
  logic [AW-1:0]                  sibling;
  logic [AW-1:0]                  left_child;
  logic [AW-1:0]                  child;
  logic [VW-1:0]                  path_max;
  logic [ffmst_pkg::GRANT_W-1:0]  leaf_grant;

  ffmst_ram #(
    .WIDTH(VW),
    .DEPTH(DEPTH)
  ) u_tree (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign in_slot   = s_axis_tdata[ffmst_pkg::SLOT_W-1:0];
  assign in_amount = s_axis_tdata[ffmst_pkg::SLOT_W +: ffmst_pkg::AMOUNT_W];
  // Amounts are kept modulo 2^VALUE_BITS.
  assign in_amt    = VW'(in_amount);
  assign slot_ok   = 32'(in_slot) < 32'(SLOTS);
  assign leaf_addr = AW'(LEAF_BASE) | AW'(in_slot);

  assign parent     = {1'b0, node[AW-1:1]};
  assign sibling    = node ^ AW'(1);
  assign left_child = {node[AW-2:0], 1'b0};
  assign child      = (rd_data >= amt) ? left_child : (left_child | AW'(1));
  assign path_max   = (cur > rd_data) ? cur : rd_data;
  assign leaf_grant = ffmst_pkg::GRANT_W'(32'(node[LEVELS-1:0]) + 32'd1);

  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    node_next     = node;
    cur_next      = cur;
    amt_next      = amt;
    is_req_next   = is_req;
    grant_next    = grant;
    m_valid_next  = m_axis_tvalid & ~m_axis_tready;
    m_data_next   = m_axis_tdata;
    ram_we        = 1'b0;
    ram_waddr     = node;
    ram_wdata     = cur;
    ram_raddr     = sibling;

    case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        ram_wdata     = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == '1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          amt_next    = in_amt;
          is_req_next = (s_axis_tuser == ffmst_pkg::FUNC_REQUEST);
          if (s_axis_tuser == ffmst_pkg::FUNC_REQUEST) begin
            ram_raddr  = AW'(1);
            state_next = ST_ROOT;
          end else if (slot_ok) begin
            // Write the leaf and fetch its sibling for the first parent.
            ram_we     = 1'b1;
            ram_waddr  = leaf_addr;
            ram_wdata  = in_amt;
            node_next  = leaf_addr;
            cur_next   = in_amt;
            ram_raddr  = leaf_addr ^ AW'(1);
            state_next = ST_UP;
          end
        end
      end
      ST_ROOT: begin
        if (rd_data < amt) begin
          grant_next = '0;
          state_next = ST_OUT;
        end else begin
          node_next  = AW'(1);
          ram_raddr  = AW'(2);
          state_next = ST_DESC;
        end
      end
      ST_DESC: begin
        // rd_data holds the left child of node; go left when it fits.
        node_next = child;
        if (child[AW-1]) begin
          ram_raddr  = child;
          state_next = ST_LEAF;
        end else begin
          ram_raddr = {child[AW-2:0], 1'b0};
        end
      end
      ST_LEAF: begin
        ram_we     = 1'b1;
        ram_waddr  = node;
        ram_wdata  = rd_data - amt;
        cur_next   = rd_data - amt;
        ram_raddr  = sibling;
        grant_next = leaf_grant;
        state_next = ST_UP;
      end
      ST_UP: begin
        // rd_data is the sibling of node; the parent takes the larger one.
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = path_max;
        cur_next  = path_max;
        node_next = parent;
        ram_raddr = parent ^ AW'(1);
        if (parent == AW'(1)) begin
          state_next = is_req ? ST_OUT : ST_IDLE;
        end
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_valid_next = 1'b1;
          m_data_next  = ffmst_pkg::OUT_TDATA_W'(grant);
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state         <= state_next;
      clr_addr      <= clr_addr_next;
      m_axis_tvalid <= m_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    node         <= node_next;
    cur          <= cur_next;
    amt          <= amt_next;
    is_req       <= is_req_next;
    grant        <= grant_next;
    m_axis_tdata <= m_data_next;
  end

endmodule

// ===== src/ffmst_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the first-fit max segment tree allocator.
// Depends on ffmst_pkg; bound to first_fit_max_segment_tree below.
module ffmst_checker #(
  parameter int SLOTS = ffmst_pkg::SLOTS_DEFAULT
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               s_axis_tuser,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [ffmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // Reset starts the clearing pass: nothing is taken and no result shows.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!s_axis_tready && !m_axis_tvalid))
    else $error("block not quiet after reset");

  // A request occupies the tree walk, so the next cycle takes nothing.
  a_request_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == ffmst_pkg::FUNC_REQUEST)
      |=> !s_axis_tready)
    else $error("input taken right after a request");

  // A stalled result holds.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // A granted slot lies within the table and the padding bits stay zero.
  a_grant_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[ffmst_pkg::OUT_TDATA_W-1:ffmst_pkg::GRANT_W] == '0) &&
      ((32'(m_axis_tdata[ffmst_pkg::GRANT_W-1:0]) <= 32'(SLOTS)) || (SLOTS >= 2048)))
    else $error("granted slot out of range");

endmodule

bind first_fit_max_segment_tree ffmst_checker #(.SLOTS(SLOTS)) u_ffmst_checker (.*);

// ===== sim/ffmst_alloc_checker.sv =====
`timescale 1ns / 1ps
// Checker for the first-fit allocator: watches both streams, keeps its own max tree
// and compares every granted slot with the prediction. Depends on ffmst_pkg.
module ffmst_alloc_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // [9:0] slot, [39:10] amount
  input  logic [ffmst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // [0] func
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [10:0] granted_slot, [15:11] zero
  input  logic [ffmst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output int                                  errors,
  output int                                  outstanding,
  output int                                  loads_seen,
  output int                                  grants_seen,
  output int                                  misses_seen
);

  localparam int LEAF_BASE  = 1 << $clog2(ffmst_pkg::SLOTS_DEFAULT);
  localparam int MAX_REPORT = 20;

  logic [ffmst_pkg::AMOUNT_W-1:0] cap_max [1:2*LEAF_BASE-1];
  logic [ffmst_pkg::GRANT_W-1:0]  grant_q [$];

  initial begin
    errors      = 0;
    outstanding = 0;
    loads_seen  = 0;
    grants_seen = 0;
    misses_seen = 0;
  end

  function automatic void refresh_to_root(int node);
    while (node > 1) begin
      node = node >> 1;
      cap_max[node] = (cap_max[2*node] > cap_max[2*node+1]) ? cap_max[2*node]
                                                             : cap_max[2*node+1];
    end
  endfunction

  // Leftmost slot with enough room; the amount is taken from it. Zero means nothing fits.
  function automatic logic [ffmst_pkg::GRANT_W-1:0] take_first_fit(
    logic [ffmst_pkg::AMOUNT_W-1:0] want
  );
    int node;
    if (cap_max[1] < want) return '0;
    node = 1;
    while (node < LEAF_BASE)
      node = (cap_max[2*node] >= want) ? 2*node : 2*node + 1;
    cap_max[node] = cap_max[node] - want;
    refresh_to_root(node);
    return ffmst_pkg::GRANT_W'(node - LEAF_BASE + 1);
  endfunction

  always @(posedge clk) begin : watch
    logic [ffmst_pkg::GRANT_W-1:0]  want_grant;
    logic [ffmst_pkg::GRANT_W-1:0]  got_grant;
    logic [ffmst_pkg::SLOT_W-1:0]   in_slot;
    logic [ffmst_pkg::AMOUNT_W-1:0] in_amount;
    if (rst) begin
      for (int i = 1; i < 2*LEAF_BASE; i++) cap_max[i] = '0;
      grant_q.delete();
    end else begin
      // A result leaving now always belongs to an earlier request, so pop first.
      if (m_axis_tvalid && m_axis_tready) begin
        got_grant = m_axis_tdata[ffmst_pkg::GRANT_W-1:0];
        if (grant_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORT)
            $display("%0t: unexpected result: expected none, got slot %0d", $time, got_grant);
        end else begin
          want_grant = grant_q.pop_front();
          if (got_grant !== want_grant) begin
            errors++;
            if (errors <= MAX_REPORT)
              $display("%0t: granted_slot mismatch: expected %0d, got %0d",
                       $time, want_grant, got_grant);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_slot   = s_axis_tdata[ffmst_pkg::SLOT_W-1:0];
        in_amount = s_axis_tdata[ffmst_pkg::SLOT_W +: ffmst_pkg::AMOUNT_W];
        if (s_axis_tuser == ffmst_pkg::FUNC_LOAD) begin
          loads_seen++;
          if (int'(in_slot) < ffmst_pkg::SLOTS_DEFAULT) begin
            cap_max[LEAF_BASE + int'(in_slot)] = in_amount;
            refresh_to_root(LEAF_BASE + int'(in_slot));
          end
        end else begin
          want_grant = take_first_fit(in_amount);
          if (want_grant == '0) misses_seen++;
          else grants_seen++;
          grant_q = {grant_q, want_grant};
        end
      end
    end
    outstanding = grant_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, load and request streams, result sink.
// Depends on ffmst_pkg, first_fit_max_segment_tree and ffmst_alloc_checker.
module tb;

  localparam int STALL_LIMIT  = 20000;
  localparam int LONG_HOLD    = 400;
  localparam int BURST_ITEMS  = 40;
  localparam int RANDOM_ITEMS = 600;
  localparam int DRAIN_CYCLES = 60;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tuser = ffmst_pkg::FUNC_LOAD;
  logic [ffmst_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                              m_axis_tready = 1'b0;
  wire                               s_axis_tready;
  wire                               m_axis_tvalid;
  wire [ffmst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  int errors, outstanding, loads_seen, grants_seen, misses_seen;
  int items_sent = 0;
  bit no_idle = 1'b0;
  bit hold_results = 1'b0;

  first_fit_max_segment_tree dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  ffmst_alloc_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .outstanding   (outstanding),
    .loads_seen    (loads_seen),
    .grants_seen   (grants_seen),
    .misses_seen   (misses_seen)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [ffmst_pkg::AMOUNT_W-1:0] rand_amount(int bits);
    return ffmst_pkg::AMOUNT_W'($urandom & ((32'd1 << bits) - 1));
  endfunction

  task automatic offer(input logic func, input logic [ffmst_pkg::SLOT_W-1:0] slot,
                       input logic [ffmst_pkg::AMOUNT_W-1:0] amount, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tuser  <= func;
    s_axis_tdata  <= {amount, slot};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic load_slot(input logic [ffmst_pkg::SLOT_W-1:0] slot,
                           input logic [ffmst_pkg::AMOUNT_W-1:0] amount);
    offer(ffmst_pkg::FUNC_LOAD, slot, amount, pick_gap());
  endtask

  // The slot field is ignored by requests, so it carries random bits.
  task automatic request_alloc(input logic [ffmst_pkg::AMOUNT_W-1:0] amount);
    offer(ffmst_pkg::FUNC_REQUEST, ffmst_pkg::SLOT_W'($urandom), amount, pick_gap());
  endtask

  initial begin : result_sink
    int run;
    int gap;
    forever begin
      if (hold_results) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_results = 1'b0;
      end
      run = $urandom_range(1, 24);
      m_axis_tready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stall_watch
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("FAIL first_fit_max_segment_tree");
    $finish;
  end

  initial begin : stimulus
    int total;
    int scale;
    int base;
    int n_loads;
    int n_reqs;
    int r;
    bit held;
    bit paused;
    logic [ffmst_pkg::AMOUNT_W-1:0] amt;

    held   = 1'b0;
    paused = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Empty tree: a zero-sized request still fits slot 1, anything else is refused.
    request_alloc('0);
    request_alloc(30'd1);
    // Full-range capacity in the last slot, then drained completely.
    load_slot(10'd1023, 30'h3FFF_FFFF);
    request_alloc(30'h3FFF_FFFF);
    request_alloc(30'd1);
    load_slot(10'd0, 30'd5);
    load_slot(10'd1, 30'd7);
    load_slot(10'd512, 30'd100);
    request_alloc(30'd6);
    request_alloc(30'd5);
    request_alloc('0);
    request_alloc(30'd50);
    request_alloc(30'd51);
    request_alloc(30'd50);
    // Alternating bit patterns on slot and amount.
    load_slot(10'h155, 30'h1555_5555);
    load_slot(10'h2AA, 30'h2AAA_AAAA);
    request_alloc(30'h1555_5555);
    request_alloc(30'h2AAA_AAAA);
    load_slot(10'd1023, '0);
    request_alloc(30'h3FFF_FFFF);

    total = items_sent + RANDOM_ITEMS;
    while (items_sent < total) begin
      no_idle = ($urandom_range(3) == 0);

      if (!held && items_sent >= 200) begin
        // Results pile up behind a stalled receiver until the input backs up.
        held = 1'b1;
        no_idle = 1'b1;
        hold_results = 1'b1;
        repeat (BURST_ITEMS) request_alloc(rand_amount(8));
        no_idle = 1'b0;
      end

      if (!paused && items_sent >= 420) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
      end

      case ($urandom_range(3))
        0:       scale = 3;
        1:       scale = 8;
        2:       scale = 16;
        default: scale = ffmst_pkg::AMOUNT_W;
      endcase

      if ($urandom_range(9) == 0) begin
        // Unstructured noise.
        repeat ($urandom_range(4, 12))
          offer(logic'($urandom_range(1)), ffmst_pkg::SLOT_W'($urandom),
                ffmst_pkg::AMOUNT_W'($urandom), pick_gap());
      end else begin
        r = $urandom_range(9);
        if (r < 6) base = $urandom_range(0, 31);
        else if (r < 8) base = $urandom_range(0, 1023);
        else base = $urandom_range(1000, 1023);
        n_loads = $urandom_range(1, 16);
        n_reqs  = $urandom_range(2, 24);
        repeat (n_loads) begin
          amt = ($urandom_range(9) == 0) ? '0 : rand_amount(scale);
          load_slot(ffmst_pkg::SLOT_W'(base + $urandom_range(0, 15)), amt);
        end
        repeat (n_reqs) begin
          r = $urandom_range(99);
          if (r < 8) amt = '0;
          else if (r < 16) amt = ffmst_pkg::AMOUNT_W'($urandom);
          else amt = rand_amount(scale);
          request_alloc(amt);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d loads, %0d requests (%0d granted, %0d refused).",
             items_sent, loads_seen, grants_seen + misses_seen, grants_seen, misses_seen);
    $display("Included a %0d-cycle output hold with back-to-back requests and a full drain.",
             LONG_HOLD);
    if (errors == 0 && outstanding == 0)
      $display("PASS first_fit_max_segment_tree");
    else
      $display("FAIL first_fit_max_segment_tree");
    $finish;
  end

endmodule
